>>> design/ffba_pkg.sv
// ffba_pkg: shared constants, codes and controller/datapath bundles
// for the first-fit block allocator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ffba_pkg;

   localparam int MAX_BLOCKS   = 16;
   localparam int HEADER_BYTES = 32;
   localparam int IDX_W        = $clog2(MAX_BLOCKS);
   localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
   localparam int SIZE_W       = 27;
   localparam int CSR_IDX_W    = 2;

   localparam logic [26:0] MAX_REQUEST_RST = 27'd100000000;
   localparam logic [31:0] HEAP_LIMIT_RST  = 32'd16777216;

   localparam logic [1:0] CMD_ALLOC   = 2'd0;
   localparam logic [1:0] CMD_ZALLOC  = 2'd1;
   localparam logic [1:0] CMD_FREE    = 2'd2;
   localparam logic [1:0] CMD_REALLOC = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_REJECT  = 2'd1;
   localparam logic [1:0] ST_NOSPACE = 2'd2;
   localparam logic [1:0] ST_NOP     = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_REQUEST = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_BASE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_LIMIT  = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic             load;       // capture request word
      logic             scan_clr;   // reset scan index
      logic             scan_step;  // advance scan index
      logic             take_free;  // reuse block at scan index
      logic             append;     // create block at heap top
      logic             release_old;// free the request's handle
      logic             keep_old;   // answer with the old handle
      logic [1:0]       status;
      logic             gives;
      logic             finish;     // load result register
   } ffba_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] cmd;
      logic       size_bad;    // zero or over limit (64-bit exact)
      logic       handle_ok;   // handle valid and below total
      logic       handle_freeable;
      logic       handle_valid;
      logic       fits_old;    // request <= old block size
      logic       scan_done;   // scan index reached total
      logic       scan_hit;    // entry at scan index is free and fits
      logic       can_grow;    // table not full and heap has room
   } ffba_stat_type;

endpackage
`default_nettype wire

>>> design/ffba_ram.sv
// ffba_ram: generic single-port write, one-port registered-read RAM.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ffba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

>>> design/ffba_ctrl.sv
// ffba_ctrl: sequencing state machine of the allocator.
// Depends on ffba_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ffba_ctrl import ffba_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_ready,
   output      logic          rsp_valid,
   input  wire logic          rsp_ready,
   input  wire ffba_stat_type stat,
   output      ffba_cmd_type  cmd
);
   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_RDOLD  = 7'b0000010,  // old block size read in flight
      S_DECIDE = 7'b0000100,
      S_RDSCAN = 7'b0001000,  // scan entry read in flight
      S_SCAN   = 7'b0010000,
      S_DONE   = 7'b0100000,
      S_RSP    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   logic take_ok;
   assign take_ok = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && take_ok;
   assign rsp_valid = rsp_valid_ff;

   logic alloc_path;
   assign alloc_path = (stat.cmd == CMD_ALLOC) || (stat.cmd == CMD_ZALLOC) ||
                       ((stat.cmd == CMD_REALLOC) && !stat.handle_valid);

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               state_in = S_RDOLD;
            end
         end
         S_RDOLD: state_in = S_DECIDE;
         S_DECIDE: begin
            cmd.scan_clr = 1'b1;
            state_in     = S_DONE;
            if (stat.cmd == CMD_FREE) begin
               if (stat.handle_freeable) begin
                  cmd.release_old = 1'b1;
                  cmd.status      = ST_OK;
               end else cmd.status = ST_NOP;
            end else if (!alloc_path && stat.size_bad) begin
               cmd.status = ST_REJECT;
            end else if (!alloc_path && !stat.handle_ok) begin
               cmd.status = ST_NOP;
            end else if (!alloc_path && stat.fits_old) begin
               cmd.keep_old = 1'b1;
               cmd.status   = ST_OK;
               cmd.gives    = 1'b1;
            end else if (stat.size_bad) begin
               cmd.status = ST_REJECT;
            end else begin
               state_in = S_RDSCAN;
            end
            if (state_in == S_DONE) cmd.finish = 1'b1;
         end
         S_RDSCAN: state_in = S_SCAN;
         S_SCAN: begin
            if (stat.scan_done) begin
               cmd.finish = 1'b1;
               state_in   = S_DONE;
               if (stat.can_grow) begin
                  cmd.append      = 1'b1;
                  cmd.release_old = !alloc_path;
                  cmd.status      = ST_OK;
                  cmd.gives       = 1'b1;
               end else cmd.status = ST_NOSPACE;
            end else if (stat.scan_hit) begin
               cmd.take_free   = 1'b1;
               cmd.release_old = !alloc_path;
               cmd.status      = ST_OK;
               cmd.gives       = 1'b1;
               cmd.finish      = 1'b1;
               state_in        = S_DONE;
            end else begin
               cmd.scan_step = 1'b1;
               state_in      = S_RDSCAN;
            end
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = S_RSP;
         end
         S_RSP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_one_hot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff) else $error("word dropped");
   a_one_finish: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> state_in == S_DONE) else $error("finish outside end");
`endif
endmodule
`default_nettype wire

>>> design/ffba_dpath.sv
// ffba_dpath: block table, counters and result register of the allocator.
// Depends on ffba_pkg and ffba_ram.
`timescale 1ns / 1ps
`default_nettype none
module ffba_dpath import ffba_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_data,
   input  wire logic [1:0]           req_cmd,
   input  wire logic [31:0]          req_size,
   input  wire logic [31:0]          req_elem_count,
   input  wire logic                 req_handle_valid,
   input  wire logic [3:0]           req_handle,
   input  wire ffba_cmd_type         cmd,
   output      ffba_stat_type        stat,
   output      logic [1:0]           rsp_status,
   output      logic [3:0]           rsp_out_handle,
   output      logic [31:0]          rsp_out_address,
   output      logic [4:0]           rsp_free_blocks,
   output      logic [31:0]          rsp_free_bytes,
   output      logic [4:0]           rsp_alloc_blocks,
   output      logic [31:0]          rsp_alloc_bytes,
   output      logic [31:0]          rsp_meta_bytes
);
   // configuration
   logic [26:0] max_request_ff;
   logic [31:0] heap_base_ff, heap_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_request_ff <= MAX_REQUEST_RST;
         heap_base_ff   <= '0;
         heap_limit_ff  <= HEAP_LIMIT_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MAX_REQUEST: max_request_ff <= csr_data[26:0];
            CSR_HEAP_BASE:   heap_base_ff   <= csr_data;
            CSR_HEAP_LIMIT:  heap_limit_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // request word
   logic [1:0]       cmd_ff;
   logic [31:0]      size_ff, cnt_ff;
   logic             hv_ff;
   logic [IDX_W-1:0] h_ff;
   logic [63:0]      prod_ff;
   logic [63:0]      need_sz;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff  <= req_cmd;
         size_ff <= req_size;
         cnt_ff  <= req_elem_count;
         hv_ff   <= req_handle_valid;
         h_ff    <= req_handle[IDX_W-1:0];
      end
      prod_ff <= {32'd0, size_ff} * {32'd0, cnt_ff};  // valid by S_DECIDE
   end

   assign need_sz = (cmd_ff == CMD_ZALLOC) ? prod_ff : {32'd0, size_ff};

   // table state
   logic [MAX_BLOCKS-1:0] free_ff;
   logic [CNT_W-1:0]      total_ff, free_cnt_ff;
   logic [31:0]           top_ff, free_bytes_ff, alloc_bytes_ff;
   logic [IDX_W-1:0]      scan_ff;
   logic [CNT_W-1:0]      scan_pos_ff;

   logic [SIZE_W-1:0] rd_size, old_size_ff;
   logic [31:0]       rd_base;
   logic [IDX_W-1:0]  rd_addr;
   logic              rd_old_ff;

   // the first read after load fetches the old handle's entry
   always_ff @(posedge clock) begin
      if (reset) rd_old_ff <= 1'b0;
      else rd_old_ff <= cmd.load;
   end
   assign rd_addr = (cmd.load || rd_old_ff) ? h_ff : scan_ff;

   always_ff @(posedge clock) if (rd_old_ff) old_size_ff <= rd_size;

   logic [31:0] new_base;
   logic [63:0] need_top;
   assign new_base = heap_base_ff + top_ff;
   assign need_top = {32'd0, top_ff} + 64'(HEADER_BYTES) + need_sz;

   ffba_ram #(.WIDTH(SIZE_W), .DEPTH(MAX_BLOCKS)) u_size (
      .clock, .wr_en(cmd.append), .wr_addr(total_ff[IDX_W-1:0]),
      .wr_data(need_sz[SIZE_W-1:0]), .rd_addr(cmd.load ? req_handle[IDX_W-1:0] : rd_addr),
      .rd_data(rd_size));
   ffba_ram #(.WIDTH(32), .DEPTH(MAX_BLOCKS)) u_base (
      .clock, .wr_en(cmd.append), .wr_addr(total_ff[IDX_W-1:0]),
      .wr_data(new_base), .rd_addr(rd_addr), .rd_data(rd_base));

   // status to controller
   logic size_bad;
   assign size_bad = (need_sz == 64'd0) || (cmd_ff == CMD_ZALLOC && cnt_ff == 32'd0) ||
                     (need_sz > {37'd0, max_request_ff});
   assign stat.cmd             = cmd_ff;
   assign stat.size_bad        = size_bad;
   assign stat.handle_valid    = hv_ff;
   assign stat.handle_ok       = hv_ff && (CNT_W'(h_ff) < total_ff);
   assign stat.handle_freeable = hv_ff && (CNT_W'(h_ff) < total_ff) && !free_ff[h_ff];
   assign stat.fits_old        = size_ff <= {5'd0, old_size_ff};
   assign stat.scan_done       = scan_pos_ff >= total_ff;
   assign stat.scan_hit        = free_ff[scan_ff] && ({37'd0, rd_size} >= need_sz);
   assign stat.can_grow        = (total_ff < CNT_W'(MAX_BLOCKS)) &&
                                 (need_top <= {32'd0, heap_limit_ff});

   always_ff @(posedge clock) begin
      if (cmd.scan_clr) begin
         scan_ff     <= '0;
         scan_pos_ff <= '0;
      end else if (cmd.scan_step) begin
         scan_ff     <= scan_ff + 1'b1;
         scan_pos_ff <= scan_pos_ff + 1'b1;
      end
   end

   // free list and counters; take and release never hit the same entry
   logic [SIZE_W-1:0] rel_size;
   assign rel_size = old_size_ff;
   logic [MAX_BLOCKS-1:0] free_in;
   logic [CNT_W-1:0]      free_cnt_in;
   logic [31:0]           free_bytes_in;

   always_comb begin
      free_in       = free_ff;
      free_cnt_in   = free_cnt_ff;
      free_bytes_in = free_bytes_ff;
      if (cmd.take_free) begin
         free_in[scan_ff] = 1'b0;
         free_cnt_in      = free_cnt_in - 1'b1;
         free_bytes_in    = free_bytes_in - {5'd0, rd_size};
      end
      // an old block that is already free stays counted once
      if (cmd.release_old && !free_ff[h_ff]) begin
         free_in[h_ff] = 1'b1;
         free_cnt_in   = free_cnt_in + 1'b1;
         free_bytes_in = free_bytes_in + {5'd0, rel_size};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff        <= '0;
         free_cnt_ff    <= '0;
         free_bytes_ff  <= '0;
         total_ff       <= '0;
         top_ff         <= '0;
         alloc_bytes_ff <= '0;
      end else begin
         free_ff       <= free_in;
         free_cnt_ff   <= free_cnt_in;
         free_bytes_ff <= free_bytes_in;
         if (cmd.append) begin
            total_ff       <= total_ff + 1'b1;
            top_ff         <= need_top[31:0];
            alloc_bytes_ff <= alloc_bytes_ff + need_sz[31:0];
         end
      end
   end

   // result register; counters sampled in the cycle after finish
   logic [1:0]  st_ff;
   logic        give_ff, res_ld_ff;
   logic [3:0]  oh_ff;
   logic [31:0] oa_ff;
   logic [31:0] meta;
   assign meta = 32'(total_ff) * 32'(HEADER_BYTES);

   always_ff @(posedge clock) begin
      if (reset) res_ld_ff <= 1'b0;
      else res_ld_ff <= cmd.finish;
      if (cmd.finish) begin
         st_ff   <= cmd.status;
         give_ff <= cmd.gives;
         if (cmd.append) begin
            oh_ff <= 4'(total_ff[IDX_W-1:0]);
            oa_ff <= new_base + 32'(HEADER_BYTES);
         end else if (cmd.keep_old) begin
            oh_ff <= 4'(h_ff);
            oa_ff <= rd_base + 32'(HEADER_BYTES);
         end else begin
            oh_ff <= 4'(scan_ff);
            oa_ff <= rd_base + 32'(HEADER_BYTES);
         end
      end
      if (res_ld_ff) begin
         rsp_status       <= st_ff;
         rsp_out_handle   <= give_ff ? oh_ff : 4'd0;
         rsp_out_address  <= give_ff ? oa_ff : 32'd0;
         rsp_free_blocks  <= 5'(free_cnt_ff);
         rsp_free_bytes   <= free_bytes_ff;
         rsp_alloc_blocks <= 5'(total_ff);
         rsp_alloc_bytes  <= alloc_bytes_ff;
         rsp_meta_bytes   <= meta;
      end
   end

`ifndef SYNTHESIS
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      free_cnt_ff == CNT_W'($countones(free_ff))) else $error("free count mismatch");
   a_take_rel: assert property (@(posedge clock) disable iff (reset)
      cmd.take_free && cmd.release_old |-> scan_ff != h_ff) else $error("same entry");
   a_total: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(MAX_BLOCKS)) else $error("table overrun");
`endif
endmodule
`default_nettype wire

>>> design/first_fit_block_allocator.sv
// first_fit_block_allocator: top level, controller plus datapath.
// Depends on ffba_pkg, ffba_ctrl, ffba_dpath, ffba_ram.
//
//  channel | handshake            | words
//  req_    | req_valid/req_ready  | cmd, size, elem_count, handle
//  rsp_    | rsp_valid/rsp_ready  | status, handle, address, counters
//  csr_    | csr_write (no wait)  | index 0..2, 32-bit data
//
// One word at a time. After accept, the controller reads the old block's
// entry and decides: free, rejects, bad handles and a realloc that fits
// in place go straight to the answer; otherwise the scan reads one entry
// per step up to the first fit, or past the last block when the heap grows.
// No new word is taken during a scan; the single read port of the
// block-size RAM paces the first-fit scan.
// Reset (synchronous) empties the table and restores the registers.
// A finished word waits in the output register; a new request is taken
// as soon as the old word leaves or in the same cycle it is taken.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_block_allocator import ffba_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [31:0] req_size,
   input  wire logic [31:0] req_elem_count,
   input  wire logic        req_handle_valid,
   input  wire logic [3:0]  req_handle,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [1:0]  rsp_status,
   output      logic [3:0]  rsp_out_handle,
   output      logic [31:0] rsp_out_address,
   output      logic [4:0]  rsp_free_blocks,
   output      logic [31:0] rsp_free_bytes,
   output      logic [4:0]  rsp_alloc_blocks,
   output      logic [31:0] rsp_alloc_bytes,
   output      logic [31:0] rsp_meta_bytes
);
   ffba_cmd_type  cmd;
   ffba_stat_type stat;

   ffba_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .stat, .cmd);

   ffba_dpath u_dpath (
      .clock, .reset, .csr_write, .csr_index, .csr_data,
      .req_cmd, .req_size, .req_elem_count, .req_handle_valid, .req_handle,
      .cmd, .stat, .rsp_status, .rsp_out_handle, .rsp_out_address,
      .rsp_free_blocks, .rsp_free_bytes, .rsp_alloc_blocks,
      .rsp_alloc_bytes, .rsp_meta_bytes);
endmodule
`default_nettype wire
